// ===== design/jkrg_pkg.sv =====
package jkrg_pkg;

  // Item codes carried in the func field
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Generator constants
  localparam logic [31:0] WEYL_STEP  = 32'd1411392427;
  localparam logic [31:0] LOW31_MASK = 32'h7FFF_FFFF;

  // Silent draws after a reseed, and the width of the counter that runs them
  localparam int unsigned WARMUP_DRAWS = 1000;
  localparam int unsigned WARM_W = (WARMUP_DRAWS < 1) ? 1 : $clog2(WARMUP_DRAWS + 1);
  localparam logic [WARM_W-1:0] WARM_LOAD = WARM_W'(WARMUP_DRAWS);

  // Generator state words
  typedef struct packed {
    logic [31:0] add_state;
    logic [31:0] shift_state;
    logic [31:0] lag_word;
    logic [31:0] carry_word;
    logic        carry_bit;
  } jkrg_state_t;

  // One 13/17/5 xorshift32 round used by the seeding
  function automatic logic [31:0] xorshift_round(input logic [31:0] s_in);
    logic [31:0] s;
    s = s_in;
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    return s;
  endfunction

  // One draw: fallback, 5/7/22 xorshift, add-with-carry, Weyl step
  function automatic jkrg_state_t draw_step(input jkrg_state_t st,
                                            input logic [31:0] fallback);
    jkrg_state_t nx;
    logic [31:0] y;
    logic [31:0] t;
    y = (st.shift_state == 32'd0) ? fallback : st.shift_state;
    y = y ^ (y << 5);
    y = y ^ (y >> 7);
    y = y ^ (y << 22);
    t = st.lag_word + st.carry_word + {31'd0, st.carry_bit};
    nx.shift_state = y;
    nx.lag_word    = st.carry_word;
    nx.carry_bit   = t[31];
    nx.carry_word  = t & LOW31_MASK;
    nx.add_state   = st.add_state + WEYL_STEP;
    return nx;
  endfunction

endpackage

// ===== design/jkrg_if.sv =====
// Request channel into the generator
interface jkrg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// Result channel out of the generator
interface jkrg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/jkiss32_random_generator.sv =====
// JKISS32-style generator with a 16-bit result. A draw request (func = 1)
// advances the state in the cycle it is accepted, and the value appears in
// the result register on the next cycle, so draws stream at one per clock
// while the result side keeps taking them. A seed request (func = 0) returns
// no value; it loads the four state words from the seed and then runs 1000
// silent draws on the same step logic, one per clock, during which
// in_ch.ready stays low. The zero fallback register is written through
// cfg_wr_en/cfg_wr_data and should only change while no request is in flight.
module jkiss32_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  jkrg_in_if.sink     in_ch,
  jkrg_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import jkrg_pkg::*;

  jkrg_state_t       st_r, st_nxt;
  jkrg_state_t       drawn;
  jkrg_state_t       seeded;
  logic [31:0]       fallback_r;
  logic [WARM_W-1:0] warm_cnt_r, warm_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_value_r;
  logic [31:0]       draw_sum;
  logic [31:0]       s1, s2, s3, s4;
  logic              busy;
  logic              in_acc;
  logic              draw_acc;

  // Stall requests during warm-up or while the result register is blocked
  assign busy        = (warm_cnt_r != '0);
  assign in_ch.ready = !busy && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign draw_acc    = in_acc && (in_ch.func == FUNC_DRAW);

  // Draw step from the current state
  assign drawn    = draw_step(st_r, fallback_r);
  assign draw_sum = drawn.add_state + drawn.shift_state + drawn.carry_word;

  // Seed chain: four xorshift rounds give the four words
  assign s1 = xorshift_round(in_ch.seed_value);
  assign s2 = xorshift_round(s1);
  assign s3 = xorshift_round(s2);
  assign s4 = xorshift_round(s3);

  always_comb begin
    seeded.add_state   = s1;
    seeded.shift_state = s2;
    seeded.lag_word    = s3;
    seeded.carry_word  = s4;
    seeded.carry_bit   = 1'b0;
  end

  // Advance the state: warm-up draws first, then accepted requests
  always_comb begin
    st_nxt       = st_r;
    warm_cnt_nxt = warm_cnt_r;
    if (busy) begin
      st_nxt       = drawn;
      warm_cnt_nxt = warm_cnt_r - WARM_W'(1);
    end else if (in_acc) begin
      if (in_ch.func == FUNC_DRAW) begin
        st_nxt = drawn;
      end else begin
        st_nxt       = seeded;
        warm_cnt_nxt = WARM_LOAD;
      end
    end
  end

  // Hold the result until taken, load on a draw
  always_comb begin
    if (draw_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      warm_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      fallback_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        fallback_r <= cfg_wr_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (draw_acc) begin
      out_value_r <= draw_sum[31:16];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

endmodule

// ===== design/jkrg_checker.sv =====
module jkrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_value
);
  import jkrg_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

  // Every accepted draw shows a result next cycle
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_DRAW) |=> out_valid)
    else $error("draw request gave no result");

  // A seed request makes no result of its own
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_SEED) && !(out_valid && !out_ready)
    |=> !out_valid)
    else $error("seed request produced a result");

  // Warm-up blocks the next request
  a_seed_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_SEED) && (WARMUP_DRAWS != 0)
    |=> !in_ready)
    else $error("request taken during warm-up");

endmodule

bind jkiss32_random_generator jkrg_checker u_jkrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);
